>>> design/tsfc_pkg.sv
// Shared types and constants for the touch sample filter and calibration block.
// Used by touch_sample_filter_calibrate; depends on nothing.
`default_nettype none

package tsfc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TAU_BITS    = 16;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 32;
    localparam int OUT_W       = 16;
    localparam int COUNT_W     = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [SAMPLE_BITS-1:0] RAW_X_IDLE_CODE = SAMPLE_BITS'(2047);
    localparam logic [COUNT_W-1:0]     COUNT_MAX       = '1;
    localparam logic [OUT_W-1:0]       OUT_MAX         = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_OFFSET  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_GAIN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_OFFSET  = 3'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw_x;
        logic [SAMPLE_BITS-1:0] raw_y;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] x_out;
        logic [OUT_W-1:0] y_out;
        logic             pressed;
    } out_t;

endpackage

`default_nettype wire

>>> design/tsfc_mul.sv
// Shared signed multiplier with a registered product.
// Used by touch_sample_filter_calibrate; no package dependency.
`default_nettype none

module tsfc_mul #(
    parameter int A_W = 29,
    parameter int B_W = 25
) (
    input  wire logic                       aclk,
    input  wire logic signed [A_W-1:0]      mul_a,
    input  wire logic signed [B_W-1:0]      mul_b,
    output logic signed [A_W+B_W-1:0]       prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

`default_nettype wire

>>> design/touch_sample_filter_calibrate.sv
// Touch sample filter with per-axis low-pass smoothing and linear calibration.
// Each item passes through eight sequencer steps around the single shared multiplier,
// six distinct products per item. A new item is accepted only in the idle step, once
// the previous item's steps are done; an untaken result stalls the final step of the
// next item until it is taken.
// Reset (aresetn low, synchronous): filter states and touch counter clear, gains
// return to 1.0, the other configuration registers clear; datapath registers hold
// no reset value.
`default_nettype none

module touch_sample_filter_calibrate #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire tsfc_pkg::in_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output tsfc_pkg::out_t                          m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tsfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tsfc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    import tsfc_pkg::*;

    localparam int SF_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int MA_W  = SF_W + 1;
    localparam int MB_W  = GAIN_W + 1;
    localparam int MP_W  = MA_W + MB_W;
    localparam int ACC_W = SF_W + TAU_BITS + 2;
    localparam int CAL_W = MP_W + 1;

    localparam logic [ACC_W-1:0]        ROUND_HALF = ACC_W'(1) << (TAU_BITS - 1);
    localparam logic [TAU_BITS:0]       TAU_ONE    = (TAU_BITS + 1)'(1) << TAU_BITS;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1 << FRAC_BITS);
    localparam logic signed [CAL_W-1:0] CAL_MAX    = CAL_W'(OUT_MAX);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_X_OLD  = 4'd1;
    localparam logic [3:0] ST_X_RAW  = 4'd2;
    localparam logic [3:0] ST_Y_OLD  = 4'd3;
    localparam logic [3:0] ST_Y_RAW  = 4'd4;
    localparam logic [3:0] ST_X_GAIN = 4'd5;
    localparam logic [3:0] ST_X_CAL  = 4'd6;
    localparam logic [3:0] ST_Y_GAIN = 4'd7;
    localparam logic [3:0] ST_Y_CAL  = 4'd8;

    logic [TAU_BITS-1:0]      smooth_reg;
    logic [COUNT_W-1:0]       settle_reg;
    logic signed [GAIN_W-1:0] x_gain_reg;
    logic signed [GAIN_W-1:0] y_gain_reg;
    logic signed [OFFSET_W-1:0] x_off_reg;
    logic signed [OFFSET_W-1:0] y_off_reg;

    logic [3:0]             step_reg, step_next;
    logic [SAMPLE_BITS-1:0] rx_reg, rx_next;
    logic [SAMPLE_BITS-1:0] ry_reg, ry_next;
    logic [SF_W-1:0]        xf_reg, xf_next;
    logic [SF_W-1:0]        yf_reg, yf_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [OUT_W-1:0]       x_cal_reg, x_cal_next;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg, m_data_next;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;
    logic [TAU_BITS:0]      inv_tau;

    logic [ACC_W-1:0]        acc_lo;
    logic [ACC_W-1:0]        acc_sum;
    logic [ACC_W-1:0]        acc_rnd;
    logic [SF_W-1:0]         rnd_state;
    logic signed [OFFSET_W-1:0] cal_off;
    logic signed [MP_W-1:0]  cal_p;
    logic signed [CAL_W-1:0] cal_v;
    logic signed [CAL_W-1:0] cal_q;
    logic [OUT_W-1:0]        cal_sat;

    logic [SAMPLE_BITS-1:0] rx_clean;
    logic                   touched;
    logic                   pressed;

    tsfc_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    assign inv_tau = TAU_ONE - (TAU_BITS + 1)'(smooth_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_X_OLD: begin
                mul_a = MA_W'(xf_reg);
                mul_b = MB_W'(smooth_reg);
            end
            ST_X_RAW: begin
                mul_a = MA_W'(rx_reg);
                mul_b = MB_W'(inv_tau);
            end
            ST_Y_OLD: begin
                mul_a = MA_W'(yf_reg);
                mul_b = MB_W'(smooth_reg);
            end
            ST_Y_RAW: begin
                mul_a = MA_W'(ry_reg);
                mul_b = MB_W'(inv_tau);
            end
            ST_X_GAIN, ST_X_CAL: begin
                mul_a = MA_W'(xf_reg);
                mul_b = MB_W'(x_gain_reg);
            end
            ST_Y_GAIN, ST_Y_CAL: begin
                mul_a = MA_W'(yf_reg);
                mul_b = MB_W'(y_gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_lo    = prod[ACC_W-1:0];
    assign acc_sum   = acc_reg + (acc_lo << FRAC_BITS);
    assign acc_rnd   = acc_reg + ROUND_HALF;
    assign rnd_state = acc_rnd[TAU_BITS +: SF_W];

    always_comb begin
        cal_off = (step_reg == ST_Y_CAL) ? y_off_reg : x_off_reg;
        cal_p   = prod >>> FRAC_BITS;
        cal_v   = CAL_W'(cal_p) + CAL_W'(cal_off);
        cal_q   = cal_v >>> FRAC_BITS;
        if (cal_q[CAL_W-1]) begin
            cal_sat = '0;
        end else if (cal_q > CAL_MAX) begin
            cal_sat = OUT_MAX;
        end else begin
            cal_sat = cal_q[OUT_W-1:0];
        end
    end

    assign rx_clean = (s_data.raw_x == RAW_X_IDLE_CODE) ? '0 : s_data.raw_x;
    assign touched  = (rx_clean != '0) && (s_data.raw_y != '0);
    assign pressed  = (count_reg >= settle_reg);

    always_comb begin
        step_next    = step_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        xf_next      = xf_reg;
        yf_next      = yf_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        x_cal_next   = x_cal_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (step_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rx_next   = rx_clean;
                    ry_next   = s_data.raw_y;
                    step_next = ST_X_OLD;
                    if (touched) begin
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end else begin
                        count_next = '0;
                        xf_next    = '0;
                        yf_next    = '0;
                    end
                end
            end
            ST_X_OLD: begin
                step_next = ST_X_RAW;
            end
            ST_X_RAW: begin
                acc_next  = acc_lo;
                step_next = ST_Y_OLD;
            end
            ST_Y_OLD: begin
                acc_next  = acc_sum;
                step_next = ST_Y_RAW;
            end
            ST_Y_RAW: begin
                xf_next   = rnd_state;
                acc_next  = acc_lo;
                step_next = ST_X_GAIN;
            end
            ST_X_GAIN: begin
                acc_next  = acc_sum;
                step_next = ST_X_CAL;
            end
            ST_X_CAL: begin
                yf_next    = rnd_state;
                x_cal_next = cal_sat;
                step_next  = ST_Y_GAIN;
            end
            ST_Y_GAIN: begin
                step_next = ST_Y_CAL;
            end
            ST_Y_CAL: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (pressed) begin
                        m_data_next.x_out   = x_cal_reg;
                        m_data_next.y_out   = cal_sat;
                        m_data_next.pressed = 1'b1;
                    end else begin
                        m_data_next = '0;
                    end
                    step_next = ST_IDLE;
                end
            end
            default: begin
                step_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
            settle_reg <= '0;
            x_gain_reg <= GAIN_ONE;
            x_off_reg  <= '0;
            y_gain_reg <= GAIN_ONE;
            y_off_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SMOOTHING: smooth_reg <= cfg_wr_data[TAU_BITS-1:0];
                CFG_SETTLE:    settle_reg <= cfg_wr_data[COUNT_W-1:0];
                CFG_X_GAIN:    x_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                CFG_X_OFFSET:  x_off_reg  <= cfg_wr_data[OFFSET_W-1:0];
                CFG_Y_GAIN:    y_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                CFG_Y_OFFSET:  y_off_reg  <= cfg_wr_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_IDLE;
            xf_reg      <= '0;
            yf_reg      <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            xf_reg      <= xf_next;
            yf_reg      <= yf_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        acc_reg    <= acc_next;
        x_cal_reg  <= x_cal_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (step_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while sequencer busy");

    a_result_from_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step_reg == ST_Y_CAL))
        else $error("result raised outside the final step");

    a_released_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pressed) |-> (m_data.x_out == '0 && m_data.y_out == '0))
        else $error("nonzero coordinates without touch");

    a_state_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_IDLE && !s_valid) |=> ($stable(xf_reg) && $stable(yf_reg)
            && $stable(count_reg)))
        else $error("filter state changed while idle");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench for touch_sample_filter_calibrate: directed and random sample traffic
// checked against an in-bench low-pass filter and calibration predictor.
// Depends on tsfc_pkg and the touch_sample_filter_calibrate RTL.
`timescale 1ns / 100ps

module testbench;
    import tsfc_pkg::*;

    localparam int FRAC        = 16;
    localparam int STATE_W     = SAMPLE_BITS + FRAC;
    localparam int DUT_LATENCY = 9;
    localparam int STALL_LIMIT = 1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam logic signed [GAIN_W-1:0]   UNITY_GAIN     = 24'sh010000;
    localparam logic signed [GAIN_W-1:0]   NEG_UNITY_GAIN = 24'shFF0000;
    localparam logic signed [GAIN_W-1:0]   GAIN_X16       = 24'sh100000;
    localparam logic signed [GAIN_W-1:0]   GAIN_MAX       = 24'sh7FFFFF;
    localparam logic signed [GAIN_W-1:0]   GAIN_MIN       = 24'sh800000;
    localparam logic signed [OFFSET_W-1:0] OFFSET_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [OFFSET_W-1:0] OFFSET_MIN     = 32'sh80000000;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    in_t                    s_data      = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    out_t                   m_data;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // predictor copy of the registers and filter state
    logic [TAU_BITS-1:0]          smooth_tau    = '0;
    logic [COUNT_W-1:0]           settle_target = '0;
    logic signed [GAIN_W-1:0]     x_gain_q      = UNITY_GAIN;
    logic signed [GAIN_W-1:0]     y_gain_q      = UNITY_GAIN;
    logic signed [OFFSET_W-1:0]   x_offset_q    = '0;
    logic signed [OFFSET_W-1:0]   y_offset_q    = '0;
    logic [STATE_W-1:0]           x_smoothed    = '0;
    logic [STATE_W-1:0]           y_smoothed    = '0;
    logic [COUNT_W-1:0]           touch_run     = '0;

    out_t expected_points[$];
    out_t want_point;
    int   fail_count    = 0;
    int   quiet_cycles  = 0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;

    touch_sample_filter_calibrate DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [STATE_W-1:0] smooth_axis(logic [STATE_W-1:0] prev,
                                                       logic [SAMPLE_BITS-1:0] raw);
        logic [63:0] acc;
        acc = 64'(prev) * 64'(smooth_tau)
            + (64'(raw) << FRAC) * ((64'd1 << TAU_BITS) - 64'(smooth_tau))
            + (64'd1 << (TAU_BITS - 1));
        return acc[TAU_BITS +: STATE_W];
    endfunction

    function automatic logic [OUT_W-1:0] calibrate_axis(logic signed [GAIN_W-1:0] gain,
                                                        logic signed [OFFSET_W-1:0] offset,
                                                        logic [STATE_W-1:0] filt);
        longint acc;
        acc = longint'(gain) * longint'(filt);
        acc = (acc >>> FRAC) + longint'(offset);
        acc = acc >>> FRAC;
        if (acc < 0)
            return '0;
        if (acc > longint'(OUT_MAX))
            return OUT_MAX;
        return acc[OUT_W-1:0];
    endfunction

    function automatic out_t predict_touch(in_t smp);
        logic [SAMPLE_BITS-1:0] rx;
        out_t                   res;
        rx = (smp.raw_x == RAW_X_IDLE_CODE) ? '0 : smp.raw_x;
        if (rx != '0 && smp.raw_y != '0) begin
            if (touch_run != COUNT_MAX)
                touch_run = touch_run + COUNT_W'(1);
        end else begin
            x_smoothed = '0;
            y_smoothed = '0;
            touch_run  = '0;
        end
        x_smoothed = smooth_axis(x_smoothed, rx);
        y_smoothed = smooth_axis(y_smoothed, smp.raw_y);
        res = '0;
        if (touch_run >= settle_target) begin
            res.x_out   = calibrate_axis(x_gain_q, x_offset_q, x_smoothed);
            res.y_out   = calibrate_axis(y_gain_q, y_offset_q, y_smoothed);
            res.pressed = 1'b1;
        end
        return res;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] rx,
                               input logic [SAMPLE_BITS-1:0] ry);
        in_t item;
        item.raw_x = rx;
        item.raw_y = ry;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_points.push_back(predict_touch(item));
    endtask

    task automatic send_touch();
        logic [SAMPLE_BITS-1:0] rx;
        do
            rx = SAMPLE_BITS'($urandom_range(1, 4095));
        while (rx == RAW_X_IDLE_CODE);
        send_sample(rx, SAMPLE_BITS'($urandom_range(1, 4095)));
    endtask

    task automatic send_release();
        case ($urandom_range(3))
            0: send_sample('0, SAMPLE_BITS'($urandom()));
            1: send_sample(RAW_X_IDLE_CODE, SAMPLE_BITS'($urandom()));
            2: send_sample(SAMPLE_BITS'($urandom()), '0);
            default: send_sample('0, '0);
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DUT_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            CFG_SMOOTHING: smooth_tau    = value[TAU_BITS-1:0];
            CFG_SETTLE:    settle_target = value[COUNT_W-1:0];
            CFG_X_GAIN:    x_gain_q      = value[GAIN_W-1:0];
            CFG_X_OFFSET:  x_offset_q    = value[OFFSET_W-1:0];
            CFG_Y_GAIN:    y_gain_q      = value[GAIN_W-1:0];
            CFG_Y_OFFSET:  y_offset_q    = value[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry junk, which must be dropped
    task automatic load_settings(input logic [TAU_BITS-1:0] tau,
                                 input logic [COUNT_W-1:0] settle,
                                 input logic signed [GAIN_W-1:0] xg,
                                 input logic signed [OFFSET_W-1:0] xo,
                                 input logic signed [GAIN_W-1:0] yg,
                                 input logic signed [OFFSET_W-1:0] yo);
        write_reg(CFG_SMOOTHING, {16'($urandom()), tau});
        write_reg(CFG_SETTLE, {16'($urandom()), settle});
        write_reg(CFG_X_GAIN, {8'($urandom()), xg});
        write_reg(CFG_X_OFFSET, xo);
        write_reg(CFG_Y_GAIN, {8'($urandom()), yg});
        write_reg(CFG_Y_OFFSET, yo);
        write_reg(CFG_UNUSED_LO, $urandom());
        write_reg(CFG_UNUSED_HI, $urandom());
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [GAIN_W-1:0] random_gain();
        if ($urandom_range(3) == 0)
            return GAIN_W'($urandom());
        return GAIN_W'(int'($urandom_range(0, 1 << 21)) - (1 << 18));
    endfunction

    function automatic logic signed [OFFSET_W-1:0] random_offset();
        if ($urandom_range(3) == 0)
            return OFFSET_W'($urandom());
        return OFFSET_W'(int'($urandom_range(0, 1 << 28)) - (1 << 26));
    endfunction

    task automatic load_random_settings();
        logic [TAU_BITS-1:0] tau;
        logic [COUNT_W-1:0]  settle;
        case ($urandom_range(3))
            0: tau = '0;
            1: tau = '1;
            default: tau = TAU_BITS'($urandom());
        endcase
        case ($urandom_range(4))
            0: settle = COUNT_W'($urandom());
            1: settle = '0;
            default: settle = COUNT_W'($urandom_range(1, 12));
        endcase
        load_settings(tau, settle, random_gain(), random_offset(),
                      random_gain(), random_offset());
    endtask

    // reset register values: no smoothing, zero settle count, unity gains
    task automatic test_default_config();
        send_sample('0, '0);
        send_sample(12'hFFF, 12'hFFF);
        send_sample(RAW_X_IDLE_CODE, 12'hFFF);
        send_sample(12'd2046, 12'd2048);
        send_sample(12'hFFF, '0);
        send_sample(12'd1, 12'd1);
        send_sample(12'hAAA, 12'h555);
        send_sample(12'h555, 12'hAAA);
    endtask

    task automatic test_smoothing_and_settle();
        wait_idle();
        load_settings(16'hFFFF, 16'd3, UNITY_GAIN, '0, UNITY_GAIN, '0);
        repeat (4) send_sample(12'hFFF, 12'hFFF);
        send_sample('0, 12'd100);
        wait_idle();
        load_settings(16'h8000, 16'd1, UNITY_GAIN, '0, UNITY_GAIN, '0);
        send_sample(12'd4000, 12'd10);
        send_sample(12'd10, 12'd4000);
        send_sample(RAW_X_IDLE_CODE, 12'd5);
    endtask

    task automatic test_calibration_limits();
        wait_idle();
        load_settings('0, '0, GAIN_MAX, '0, GAIN_MIN, '0);
        send_sample(12'hFFF, 12'hFFF);
        send_sample(12'd1, 12'd1);
        wait_idle();
        load_settings('0, '0, GAIN_X16, OFFSET_MAX, UNITY_GAIN, OFFSET_MIN);
        send_sample(12'hFFF, 12'hFFF);
        send_sample('0, '0);
        wait_idle();
        load_settings('0, '0, NEG_UNITY_GAIN, OFFSET_MAX, GAIN_MIN, OFFSET_MAX);
        send_sample(12'd2048, 12'd2048);
    endtask

    // mostly touch runs of random length, each opened by a release, plus noise
    task automatic test_random_traffic(input int idle_src, input int idle_sink);
        int run_left;
        src_idle_pct  = idle_src;
        sink_idle_pct = idle_sink;
        repeat (3) begin
            wait_idle();
            load_random_settings();
            run_left = 0;
            repeat (110) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 40);
                    send_release();
                end else if ($urandom_range(19) == 0) begin
                    send_sample(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()));
                end else begin
                    send_touch();
                    run_left--;
                end
            end
        end
    endtask

    // long touch run across a large settle count, then release and touch again
    task automatic test_long_touch_run();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        wait_idle();
        load_settings(TAU_BITS'($urandom()), 16'd32, UNITY_GAIN, '0, UNITY_GAIN, '0);
        send_release();
        repeat (40) send_touch();
        send_release();
        repeat (2) send_touch();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end else begin
                want_point = expected_points.pop_front();
                if (m_data.x_out !== want_point.x_out) begin
                    $error("x_out: expected %0d, got %0d", want_point.x_out, m_data.x_out);
                    fail_count++;
                end
                if (m_data.y_out !== want_point.y_out) begin
                    $error("y_out: expected %0d, got %0d", want_point.y_out, m_data.y_out);
                    fail_count++;
                end
                if (m_data.pressed !== want_point.pressed) begin
                    $error("pressed: expected %0d, got %0d",
                           want_point.pressed, m_data.pressed);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("[touch_sample_filter_calibrate] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn       <= 1'b1;
        src_idle_pct  = 37;
        sink_idle_pct = 49;
        test_default_config();
        test_smoothing_and_settle();
        test_calibration_limits();
        test_random_traffic(37, 49);
        test_random_traffic(49, 37);
        test_random_traffic(0, 0);
        test_long_touch_run();
        wait_idle();
        if (fail_count == 0)
            $display("[touch_sample_filter_calibrate] OK");
        else
            $display("[touch_sample_filter_calibrate] ERROR");
        $finish;
    end

endmodule

>>> files.f
design/tsfc_pkg.sv
design/tsfc_mul.sv
design/touch_sample_filter_calibrate.sv
tb/testbench.sv
